>>> src/bssd_pkg.sv
// ----------------------------------------------------------------------------
// Bump switch speed derating package
// Register indexes, item codes and scaling constants shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package bssd_pkg;

    localparam int TIME_W  = 32;
    localparam int DEB_W   = 16;
    localparam int PCT_W   = 7;
    localparam int STICK_W = 8;
    localparam int CFG_W   = 16;

    // Reciprocal of 100 scaled by 2^RECIP_SHIFT; exact for every |stick| * percent here
    localparam int RECIP_SHIFT = 19;
    localparam int RECIP_100   = 5243;
    localparam int SCALE_W     = 20;
    localparam int PROD_W      = STICK_W + SCALE_W;
    localparam int QUOT_W      = 9;

    localparam logic [DEB_W-1:0] DEBOUNCE_RST  = 16'd50;
    localparam logic [PCT_W-1:0] COLLISION_RST = 7'd40;
    localparam logic [PCT_W-1:0] NORMAL_RST    = 7'd100;
    localparam logic [PCT_W-1:0] RAMP_RST      = 7'd12;
    localparam logic [PCT_W-1:0] SPEED_RST     = 7'd100;

    typedef enum logic [1:0] {
        REG_DEBOUNCE  = 2'd0,
        REG_COLLISION = 2'd1,
        REG_NORMAL    = 2'd2,
        REG_RAMP      = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        FUNC_POLL  = 1'b0,
        FUNC_DRIVE = 1'b1
    } func_t;

endpackage

`default_nettype wire

>>> src/bump_switch_speed_derating.sv
// ----------------------------------------------------------------------------
// Bump switch speed derating
// Debounces two bump switches, ramps each motor's speed percent toward its
// target and scales stick commands by the current percents.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one request per cycle unless
//   stalled by out_ready: a poll request (func = 0) with time and switch
//   levels, or a drive request (func = 1) with two signed stick values.
//   Output channel (out_valid/out_ready) returns one result per request, in
//   order. A request is held in the input register, then in the result
//   register, which drives out_valid. Throughput is one request per cycle
//   while out_ready stays high, set by the input register feeding the result
//   register through a single pass of logic. If the receiver stalls, the
//   result register holds and the input register still takes one more
//   request; in_ready then drops until the result is taken.
//   Reset empties both registers and restores switch levels (open), time
//   stamps (0), targets and speeds (100) and the configuration defaults.
//   Configuration writes (cfg_wr_en, cfg_index, cfg_data) take effect at once;
//   make them only while the block is idle: the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module bump_switch_speed_derating
    import bssd_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,

    input  wire logic                      cfg_wr_en,
    input  wire logic [1:0]                cfg_index,
    input  wire logic [CFG_W-1:0]          cfg_data,

    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic                      func,
    input  wire logic [TIME_W-1:0]         time_ms,
    input  wire logic                      right_switch,
    input  wire logic                      left_switch,
    input  wire logic signed [STICK_W-1:0] left_stick,
    input  wire logic signed [STICK_W-1:0] right_stick,

    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic signed [STICK_W-1:0]      left_drive,
    output logic signed [STICK_W-1:0]      right_drive,
    output logic [PCT_W-1:0]               left_percent_now,
    output logic [PCT_W-1:0]               right_percent_now
);

    logic [DEB_W-1:0]          debounce_reg;
    logic [PCT_W-1:0]          collision_reg;
    logic [PCT_W-1:0]          normal_reg;
    logic [PCT_W-1:0]          ramp_reg;

    logic                      in_valid_reg;
    logic                      func_reg;
    logic [TIME_W-1:0]         time_reg;
    logic                      right_sw_reg;
    logic                      left_sw_reg;
    logic signed [STICK_W-1:0] left_stick_reg;
    logic signed [STICK_W-1:0] right_stick_reg;

    logic                      right_level_reg;
    logic                      left_level_reg;
    logic [TIME_W-1:0]         right_stamp_reg;
    logic [TIME_W-1:0]         left_stamp_reg;
    logic [PCT_W-1:0]          left_target_reg;
    logic [PCT_W-1:0]          right_target_reg;
    logic [PCT_W-1:0]          left_speed_reg;
    logic [PCT_W-1:0]          right_speed_reg;
    logic [SCALE_W-1:0]        left_scale_reg;
    logic [SCALE_W-1:0]        right_scale_reg;

    logic                      out_valid_reg;
    logic signed [STICK_W-1:0] left_drive_reg;
    logic signed [STICK_W-1:0] right_drive_reg;
    logic [PCT_W-1:0]          left_pct_reg;
    logic [PCT_W-1:0]          right_pct_reg;

    logic                      out_free;
    logic                      adv;
    logic                      is_poll;
    logic                      right_change;
    logic                      left_change;
    logic                      right_level_next;
    logic                      left_level_next;
    logic [TIME_W-1:0]         right_stamp_next;
    logic [TIME_W-1:0]         left_stamp_next;
    logic [PCT_W-1:0]          left_target_next;
    logic [PCT_W-1:0]          right_target_next;
    logic [PCT_W-1:0]          left_speed_next;
    logic [PCT_W-1:0]          right_speed_next;
    logic [SCALE_W-1:0]        left_scale_next;
    logic [SCALE_W-1:0]        right_scale_next;
    logic signed [STICK_W-1:0] left_drive_next;
    logic signed [STICK_W-1:0] right_drive_next;

    function automatic logic [PCT_W-1:0] ramp_to(
        input logic [PCT_W-1:0] speed,
        input logic [PCT_W-1:0] target,
        input logic [PCT_W-1:0] step
    );
        logic [PCT_W:0] up;
        logic [PCT_W:0] lim;
        logic [PCT_W-1:0] res;
        up  = {1'b0, speed} + {1'b0, step};
        lim = {1'b0, target} + {1'b0, step};
        res = speed;
        priority if (speed < target)
        begin
            res = (up > {1'b0, target}) ? target : up[PCT_W-1:0];
        end
        else if (speed > target)
        begin
            res = ({1'b0, speed} < lim) ? target : (speed - step);
        end
        return res;
    endfunction

    function automatic logic signed [STICK_W-1:0] scale_stick(
        input logic signed [STICK_W-1:0] stick,
        input logic [SCALE_W-1:0]        scale
    );
        logic [STICK_W-1:0] mag;
        logic [PROD_W-1:0]  prod;
        logic [QUOT_W-1:0]  quot;
        logic [QUOT_W-1:0]  neg_q;
        logic signed [STICK_W-1:0] res;
        mag   = stick[STICK_W-1] ? (~stick + 1'b1) : stick;
        prod  = PROD_W'(mag) * PROD_W'(scale);
        quot  = QUOT_W'(prod >> RECIP_SHIFT);
        neg_q = ~quot + 1'b1;
        if (stick[STICK_W-1])
        begin
            res = (quot > QUOT_W'(128)) ? 8'sh80 : neg_q[STICK_W-1:0];
        end
        else
        begin
            res = (quot > QUOT_W'(127)) ? 8'sh7f : quot[STICK_W-1:0];
        end
        return res;
    endfunction

    assign out_free = !out_valid_reg || out_ready;
    assign adv      = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || out_free;
    assign is_poll  = (func_t'(func_reg) == FUNC_POLL);

    assign right_change = (right_sw_reg != right_level_reg) &&
                          ((time_reg - right_stamp_reg) > TIME_W'(debounce_reg));
    assign left_change  = (left_sw_reg != left_level_reg) &&
                          ((time_reg - left_stamp_reg) > TIME_W'(debounce_reg));

    always_comb
    begin
        right_level_next  = right_level_reg;
        left_level_next   = left_level_reg;
        right_stamp_next  = right_stamp_reg;
        left_stamp_next   = left_stamp_reg;
        left_target_next  = left_target_reg;
        right_target_next = right_target_reg;
        if (right_change)
        begin
            right_level_next = right_sw_reg;
            right_stamp_next = time_reg;
            left_target_next = right_sw_reg ? normal_reg : collision_reg;
        end
        if (left_change)
        begin
            left_level_next   = left_sw_reg;
            left_stamp_next   = time_reg;
            right_target_next = left_sw_reg ? normal_reg : collision_reg;
        end
        left_speed_next  = ramp_to(left_speed_reg, left_target_next, ramp_reg);
        right_speed_next = ramp_to(right_speed_reg, right_target_next, ramp_reg);
        left_scale_next  = SCALE_W'(left_speed_next) * SCALE_W'(RECIP_100);
        right_scale_next = SCALE_W'(right_speed_next) * SCALE_W'(RECIP_100);
        left_drive_next  = scale_stick(left_stick_reg, left_scale_reg);
        right_drive_next = scale_stick(right_stick_reg, right_scale_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg  <= DEBOUNCE_RST;
            collision_reg <= COLLISION_RST;
            normal_reg    <= NORMAL_RST;
            ramp_reg      <= RAMP_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_DEBOUNCE:  debounce_reg  <= cfg_data;
                REG_COLLISION: collision_reg <= cfg_data[PCT_W-1:0];
                REG_NORMAL:    normal_reg    <= cfg_data[PCT_W-1:0];
                REG_RAMP:      ramp_reg      <= cfg_data[PCT_W-1:0];
                default:       ramp_reg      <= ramp_reg;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            func_reg        <= func;
            time_reg        <= time_ms;
            right_sw_reg    <= right_switch;
            left_sw_reg     <= left_switch;
            left_stick_reg  <= left_stick;
            right_stick_reg <= right_stick;
        end
    end

    // State advances once per poll request as it leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            right_level_reg  <= 1'b1;
            left_level_reg   <= 1'b1;
            right_stamp_reg  <= '0;
            left_stamp_reg   <= '0;
            left_target_reg  <= SPEED_RST;
            right_target_reg <= SPEED_RST;
            left_speed_reg   <= SPEED_RST;
            right_speed_reg  <= SPEED_RST;
            left_scale_reg   <= SCALE_W'(SPEED_RST) * SCALE_W'(RECIP_100);
            right_scale_reg  <= SCALE_W'(SPEED_RST) * SCALE_W'(RECIP_100);
        end
        else if (adv && is_poll)
        begin
            right_level_reg  <= right_level_next;
            left_level_reg   <= left_level_next;
            right_stamp_reg  <= right_stamp_next;
            left_stamp_reg   <= left_stamp_next;
            left_target_reg  <= left_target_next;
            right_target_reg <= right_target_next;
            left_speed_reg   <= left_speed_next;
            right_speed_reg  <= right_speed_next;
            left_scale_reg   <= left_scale_next;
            right_scale_reg  <= right_scale_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (is_poll)
            begin
                left_drive_reg  <= '0;
                right_drive_reg <= '0;
                left_pct_reg    <= left_speed_next;
                right_pct_reg   <= right_speed_next;
            end
            else
            begin
                left_drive_reg  <= left_drive_next;
                right_drive_reg <= right_drive_next;
                left_pct_reg    <= left_speed_reg;
                right_pct_reg   <= right_speed_reg;
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign left_drive        = left_drive_reg;
    assign right_drive       = right_drive_reg;
    assign left_percent_now  = left_pct_reg;
    assign right_percent_now = right_pct_reg;

    a_drive_keeps_speed: assert property (@(posedge clk) disable iff (!rst_n)
        adv && !is_poll |=> $stable(left_speed_reg) && $stable(right_speed_reg))
        else $error("speed changed on a drive request");

    a_idle_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(left_stamp_reg) && $stable(right_stamp_reg) &&
                 $stable(left_level_reg) && $stable(right_level_reg))
        else $error("switch state changed without a request");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with an empty result register");

    a_scale_tracks_speed: assert property (@(posedge clk) disable iff (!rst_n)
        left_scale_reg == SCALE_W'(left_speed_reg) * SCALE_W'(RECIP_100) &&
        right_scale_reg == SCALE_W'(right_speed_reg) * SCALE_W'(RECIP_100))
        else $error("scale factor out of step with speed");

    a_ramp_no_overshoot: assert property (@(posedge clk) disable iff (!rst_n)
        adv && is_poll && left_speed_reg <= left_target_next
        |=> left_speed_reg <= left_target_reg)
        else $error("left ramp passed its target");

endmodule

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bump switch speed derating testbench
// A directed table runs first, then random poll and drive requests under
// several register settings and handshake idling patterns. Typed table rows
// are checked against their listed results; every other result is compared
// against a local predictor of switch debounce, speed ramping and stick scaling.
// ----------------------------------------------------------------------------

module tb;
    import bssd_pkg::*;

    typedef struct packed {
        func_t                     op;
        logic [TIME_W-1:0]         now_ms;
        logic                      rsw;
        logic                      lsw;
        logic signed [STICK_W-1:0] lstick;
        logic signed [STICK_W-1:0] rstick;
    } bump_req_t;

    typedef struct packed {
        logic signed [STICK_W-1:0] ldrive;
        logic signed [STICK_W-1:0] rdrive;
        logic [PCT_W-1:0]          lpct;
        logic [PCT_W-1:0]          rpct;
    } bump_res_t;

    typedef struct packed {
        bump_req_t req;
        logic      typed;
        bump_res_t want;
    } table_row_t;

    localparam int N_ROWS = 21;

    table_row_t dir_rows [N_ROWS] = '{
        '{'{FUNC_DRIVE, 32'd0, 1'b1, 1'b1, 8'sd127, -8'sd128}, 1'b1,
          '{8'sd127, -8'sd128, 7'd100, 7'd100}},
        '{'{FUNC_DRIVE, 32'd0, 1'b1, 1'b1, -8'sd1, 8'sd1}, 1'b1,
          '{-8'sd1, 8'sd1, 7'd100, 7'd100}},
        '{'{FUNC_DRIVE, 32'd0, 1'b1, 1'b1, 8'sd0, 8'sd0}, 1'b1,
          '{8'sd0, 8'sd0, 7'd100, 7'd100}},
        '{'{FUNC_POLL, 32'd0, 1'b1, 1'b1, 8'sd0, 8'sd0}, 1'b1,
          '{8'sd0, 8'sd0, 7'd100, 7'd100}},
        '{'{FUNC_POLL, 32'd50, 1'b0, 1'b1, 8'sd0, 8'sd0}, 1'b1,
          '{8'sd0, 8'sd0, 7'd100, 7'd100}},
        '{'{FUNC_POLL, 32'd51, 1'b0, 1'b1, 8'sd0, 8'sd0}, 1'b1,
          '{8'sd0, 8'sd0, 7'd88, 7'd100}},
        '{'{FUNC_POLL, 32'd52, 1'b0, 1'b0, 8'sd0, 8'sd0}, 1'b1,
          '{8'sd0, 8'sd0, 7'd76, 7'd88}},
        '{'{FUNC_DRIVE, 32'd0, 1'b1, 1'b1, 8'sd127, 8'sd127}, 1'b0, '0},
        '{'{FUNC_POLL, 32'd53, 1'b0, 1'b0, 8'sd0, 8'sd0}, 1'b0, '0},
        '{'{FUNC_POLL, 32'd54, 1'b0, 1'b0, 8'sd0, 8'sd0}, 1'b0, '0},
        '{'{FUNC_POLL, 32'd55, 1'b0, 1'b0, 8'sd0, 8'sd0}, 1'b0, '0},
        '{'{FUNC_POLL, 32'd56, 1'b0, 1'b0, 8'sd0, 8'sd0}, 1'b0, '0},
        '{'{FUNC_DRIVE, 32'd0, 1'b0, 1'b0, -8'sd128, -8'sd128}, 1'b0, '0},
        '{'{FUNC_POLL, 32'd60, 1'b1, 1'b0, 8'sd0, 8'sd0}, 1'b0, '0},
        '{'{FUNC_POLL, 32'd102, 1'b1, 1'b0, 8'sd0, 8'sd0}, 1'b0, '0},
        '{'{FUNC_POLL, 32'hFFFF_FFF0, 1'b0, 1'b1, 8'sd0, 8'sd0}, 1'b0, '0},
        '{'{FUNC_POLL, 32'h0000_0020, 1'b1, 1'b1, 8'sd0, 8'sd0}, 1'b0, '0},
        '{'{FUNC_POLL, 32'h0000_0023, 1'b1, 1'b1, 8'sd0, 8'sd0}, 1'b0, '0},
        '{'{FUNC_POLL, 32'hFFFF_FFFF, 1'b1, 1'b1, -8'sd1, -8'sd1}, 1'b0, '0},
        '{'{FUNC_DRIVE, 32'hFFFF_FFFF, 1'b0, 1'b0, 8'sd127, -8'sd128}, 1'b0, '0},
        '{'{FUNC_DRIVE, 32'd0, 1'b1, 1'b1, 8'sd100, -8'sd100}, 1'b0, '0}
    };

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [1:0]                cfg_index = REG_DEBOUNCE;
    logic [CFG_W-1:0]          cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic                      func = FUNC_POLL;
    logic [TIME_W-1:0]         time_ms = '0;
    logic                      right_switch = 1'b1;
    logic                      left_switch = 1'b1;
    logic signed [STICK_W-1:0] left_stick = '0;
    logic signed [STICK_W-1:0] right_stick = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic signed [STICK_W-1:0] left_drive;
    logic signed [STICK_W-1:0] right_drive;
    logic [PCT_W-1:0]          left_percent_now;
    logic [PCT_W-1:0]          right_percent_now;

    // predictor state and register copies
    logic              kept_r = 1'b1;
    logic              kept_l = 1'b1;
    logic [TIME_W-1:0] stamp_r = '0;
    logic [TIME_W-1:0] stamp_l = '0;
    logic [PCT_W-1:0]  aim_l = SPEED_RST;
    logic [PCT_W-1:0]  aim_r = SPEED_RST;
    logic [PCT_W-1:0]  pct_l = SPEED_RST;
    logic [PCT_W-1:0]  pct_r = SPEED_RST;
    logic [DEB_W-1:0]  dly_ms = DEBOUNCE_RST;
    logic [PCT_W-1:0]  pct_hit = COLLISION_RST;
    logic [PCT_W-1:0]  pct_free = NORMAL_RST;
    logic [PCT_W-1:0]  step = RAMP_RST;

    bump_res_t due_results [$];
    int        mismatches = 0;
    int        send_idle = 0;
    int        stall_pct = 0;

    bump_switch_speed_derating u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .func              (func),
        .time_ms           (time_ms),
        .right_switch      (right_switch),
        .left_switch       (left_switch),
        .left_stick        (left_stick),
        .right_stick       (right_stick),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .left_drive        (left_drive),
        .right_drive       (right_drive),
        .left_percent_now  (left_percent_now),
        .right_percent_now (right_percent_now)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic logic [PCT_W-1:0] ramp_toward(input logic [PCT_W-1:0] cur,
                                                     input logic [PCT_W-1:0] aim);
        int c;
        int a;
        int s;
        c = cur;
        a = aim;
        s = step;
        if (c < a)
            return (c + s > a) ? aim : PCT_W'(c + s);
        if (c > a)
            return (c < a + s) ? aim : PCT_W'(c - s);
        return cur;
    endfunction

    function automatic logic signed [STICK_W-1:0] scale_stick(
        input logic signed [STICK_W-1:0] s, input logic [PCT_W-1:0] p);
        int v;
        v = int'(s) * int'(p) / 100;
        if (v > 127)
            v = 127;
        if (v < -128)
            v = -128;
        return STICK_W'(v);
    endfunction

    function automatic bump_res_t derate_step(input bump_req_t q);
        bump_res_t         r;
        logic [TIME_W-1:0] since;
        r = '0;
        if (q.op == FUNC_POLL)
        begin
            since = q.now_ms - stamp_r;
            if (q.rsw != kept_r && since > TIME_W'(dly_ms))
            begin
                kept_r  = q.rsw;
                stamp_r = q.now_ms;
                aim_l   = q.rsw ? pct_free : pct_hit;
            end
            since = q.now_ms - stamp_l;
            if (q.lsw != kept_l && since > TIME_W'(dly_ms))
            begin
                kept_l  = q.lsw;
                stamp_l = q.now_ms;
                aim_r   = q.lsw ? pct_free : pct_hit;
            end
            pct_l = ramp_toward(pct_l, aim_l);
            pct_r = ramp_toward(pct_r, aim_r);
        end
        else
        begin
            r.ldrive = scale_stick(q.lstick, pct_l);
            r.rdrive = scale_stick(q.rstick, pct_r);
        end
        r.lpct = pct_l;
        r.rpct = pct_r;
        return r;
    endfunction

    task automatic push_request(input bump_req_t q, input logic typed,
                                input bump_res_t want);
        bump_res_t calc;
        if (send_idle > 0 && $urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle);
        end
        in_valid     <= 1'b1;
        func         <= q.op;
        time_ms      <= q.now_ms;
        right_switch <= q.rsw;
        left_switch  <= q.lsw;
        left_stick   <= q.lstick;
        right_stick  <= q.rstick;
        do
            @(posedge clk);
        while (!in_ready);
        calc = derate_step(q);
        due_results.push_back(typed ? want : calc);
    endtask

    task automatic drain_results();
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_regs(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] hit,
                                input logic [CFG_W-1:0] free, input logic [CFG_W-1:0] inc);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_DEBOUNCE;
        cfg_data  <= deb;
        @(posedge clk);
        cfg_index <= REG_COLLISION;
        cfg_data  <= hit;
        @(posedge clk);
        cfg_index <= REG_NORMAL;
        cfg_data  <= free;
        @(posedge clk);
        cfg_index <= REG_RAMP;
        cfg_data  <= inc;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        dly_ms   = deb[DEB_W-1:0];
        pct_hit  = hit[PCT_W-1:0];
        pct_free = free[PCT_W-1:0];
        step     = inc[PCT_W-1:0];
    endtask

    always @(posedge clk)
    begin : check_results
        bump_res_t got;
        bump_res_t exp_res;
        got = '{left_drive, right_drive, left_percent_now, right_percent_now};
        if (rst_n && out_valid && out_ready)
        begin
            if (due_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: ld=%0d rd=%0d lp=%0d rp=%0d",
                             got.ldrive, got.rdrive, got.lpct, got.rpct);
            end
            else
            begin
                exp_res = due_results.pop_front();
                if (got.ldrive !== exp_res.ldrive || got.rdrive !== exp_res.rdrive ||
                    got.lpct !== exp_res.lpct || got.rpct !== exp_res.rpct)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected ld=%0d rd=%0d lp=%0d rp=%0d, ",
                                 exp_res.ldrive, exp_res.rdrive,
                                 exp_res.lpct, exp_res.rpct,
                                 "got ld=%0d rd=%0d lp=%0d rp=%0d",
                                 got.ldrive, got.rdrive, got.lpct, got.rpct);
                end
            end
        end
    end

    initial
    begin
        #400000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        bump_req_t         q;
        logic              lvl_r;
        logic              lvl_l;
        logic [TIME_W-1:0] clock_ms;
        int                p;
        int                n;
        lvl_r    = 1'b1;
        lvl_l    = 1'b1;
        clock_ms = 32'd1000;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        for (n = 0; n < N_ROWS; n++)
            push_request(dir_rows[n].req, dir_rows[n].typed, dir_rows[n].want);

        for (p = 0; p < 8; p++)
        begin
            in_valid <= 1'b0;
            drain_results();
            unique case (p)
                0: program_regs(16'd0, 16'd0, 16'd127, 16'd127);
                1: program_regs(16'hFFFF, 16'd100, 16'd100, 16'd1);
                2: program_regs(16'd7, 16'd30, 16'd90, 16'd0);
                3: program_regs(16'd50, 16'd40, 16'd100, 16'd12);
                default: program_regs(CFG_W'($urandom_range(0, 200)),
                                      CFG_W'($urandom_range(0, 127)),
                                      CFG_W'($urandom_range(0, 127)),
                                      CFG_W'($urandom_range(1, 30)));
            endcase
            unique case (p % 4)
                0: begin send_idle = 0;  stall_pct = 0;  end
                1: begin send_idle = 47; stall_pct = 0;  end
                2: begin send_idle = 0;  stall_pct = 47; end
                default: begin send_idle = 29; stall_pct = 29; end
            endcase
            for (n = 0; n < 125; n++)
            begin
                q.rsw    = 1'($urandom_range(1));
                q.lsw    = 1'($urandom_range(1));
                q.now_ms = $urandom();
                if ($urandom_range(99) < 55)
                begin
                    q.op = FUNC_POLL;
                    if ($urandom_range(99) < 4)
                        clock_ms = $urandom();
                    else
                        clock_ms += $urandom_range(0, int'(dly_ms) * 3 / 2 + 3);
                    if ($urandom_range(99) < 25)
                        lvl_r = ~lvl_r;
                    if ($urandom_range(99) < 25)
                        lvl_l = ~lvl_l;
                    q.now_ms = clock_ms;
                    q.rsw    = lvl_r;
                    q.lsw    = lvl_l;
                end
                else
                    q.op = FUNC_DRIVE;
                if ($urandom_range(99) < 10)
                begin
                    q.lstick = $urandom_range(1) ? 8'sd127 : -8'sd128;
                    q.rstick = $urandom_range(1) ? 8'sd127 : -8'sd128;
                end
                else
                begin
                    q.lstick = STICK_W'($urandom());
                    q.rstick = STICK_W'($urandom());
                end
                push_request(q, 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        drain_results();
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
